>>> sv/hfp_pkg.sv
package hfp_pkg;

  // parse phases
  typedef enum logic [3:0] {
    PH_SIGN_OR_ZERO = 4'd0,
    PH_ZERO         = 4'd1,
    PH_X            = 4'd2,
    PH_FIRST        = 4'd3,
    PH_POINT_OR_P   = 4'd4,
    PH_FRACTION     = 4'd5,
    PH_EXP_SIGN     = 4'd6,
    PH_EXP_DIGITS   = 4'd7,
    PH_ERROR        = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ZERO = 2'd1,
    ST_NO_X    = 2'd2,
    ST_NO_P    = 2'd3
  } status_t;

  // ascii codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_X     = 8'h78;

  // 'a' maps to ten
  localparam logic [63:0] HEX_ALPHA_BIAS = 64'(CH_A) - 64'd10;

  typedef struct packed {
    phase_t      phase;
    logic        mant_neg;
    logic [63:0] mant_acc;
    logic [31:0] frac_digits;
    logic [31:0] exp_acc;
    logic        exp_neg;
    status_t     err;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:       PH_SIGN_OR_ZERO,
    mant_neg:    1'b0,
    mant_acc:    64'd0,
    frac_digits: 32'd0,
    exp_acc:     32'd0,
    exp_neg:     1'b0,
    err:         ST_OK
  };

  typedef struct packed {
    logic        done;
    status_t     status;
    logic [63:0] mantissa;
    logic [31:0] binary_exponent;
  } parse_result_t;

endpackage

>>> sv/hfp_step.sv
module hfp_step (
  input  hfp_pkg::parse_state_t  cur,
  input  logic [7:0]             chr,
  output hfp_pkg::parse_state_t  nxt,
  output hfp_pkg::parse_result_t res
);
  import hfp_pkg::*;

  logic [63:0] digit;
  logic [31:0] dec;
  logic [63:0] signed_mant;
  logic [31:0] signed_exp;

  // no range check: non-digits add their wrapped value
  assign digit = (chr >= CH_A) ? (64'(chr) - HEX_ALPHA_BIAS) : (64'(chr) - 64'(CH_ZERO));
  assign dec   = 32'(chr) - 32'(CH_ZERO);

  assign signed_mant = cur.mant_neg ? (64'd0 - cur.mant_acc) : cur.mant_acc;
  assign signed_exp  = cur.exp_neg ? (32'd0 - cur.exp_acc) : cur.exp_acc;

  always_comb begin
    nxt = cur;
    res = '{done: 1'b0, status: ST_OK, mantissa: 64'd0, binary_exponent: 32'd0};
    if (chr == CH_NUL) begin
      res.done = 1'b1;
      case (cur.phase)
        PH_ERROR:                  res.status = cur.err;
        PH_SIGN_OR_ZERO, PH_ZERO:  res.status = ST_NO_ZERO;
        PH_X:                      res.status = ST_NO_X;
        PH_FIRST, PH_POINT_OR_P,
        PH_FRACTION:               res.status = ST_NO_P;
        default: begin
          res.status          = ST_OK;
          res.mantissa        = signed_mant;
          res.binary_exponent = signed_exp - {cur.frac_digits[29:0], 2'b00};
        end
      endcase
      nxt = PARSE_RESET;
    end else begin
      case (cur.phase)
        PH_SIGN_OR_ZERO: begin
          if (chr == CH_MINUS) begin
            nxt.mant_neg = 1'b1;
            nxt.phase    = PH_ZERO;
          end else if (chr == CH_ZERO) begin
            nxt.phase = PH_X;
          end else begin
            nxt.err   = ST_NO_ZERO;
            nxt.phase = PH_ERROR;
          end
        end
        PH_ZERO: begin
          if (chr == CH_ZERO) begin
            nxt.phase = PH_X;
          end else begin
            nxt.err   = ST_NO_ZERO;
            nxt.phase = PH_ERROR;
          end
        end
        PH_X: begin
          if (chr == CH_X) begin
            nxt.phase = PH_FIRST;
          end else begin
            nxt.err   = ST_NO_X;
            nxt.phase = PH_ERROR;
          end
        end
        PH_FIRST: begin
          nxt.mant_acc = digit;
          nxt.phase    = PH_POINT_OR_P;
        end
        PH_POINT_OR_P: begin
          if (chr == CH_POINT) begin
            nxt.phase = PH_FRACTION;
          end else if (chr == CH_P) begin
            nxt.phase = PH_EXP_SIGN;
          end else begin
            nxt.err   = ST_NO_P;
            nxt.phase = PH_ERROR;
          end
        end
        PH_FRACTION: begin
          if (chr == CH_P) begin
            nxt.phase = PH_EXP_SIGN;
          end else begin
            nxt.mant_acc    = {cur.mant_acc[59:0], 4'h0} + digit;
            nxt.frac_digits = cur.frac_digits + 32'd1;
          end
        end
        PH_EXP_SIGN: begin
          nxt.phase = PH_EXP_DIGITS;
          if (chr == CH_MINUS) begin
            nxt.exp_neg = 1'b1;
          end else if (chr != CH_PLUS) begin
            nxt.exp_acc = dec;
          end
        end
        PH_EXP_DIGITS: begin
          // times ten as two shifts
          nxt.exp_acc = {cur.exp_acc[28:0], 3'b000} + {cur.exp_acc[30:0], 1'b0} + dec;
        end
        default: begin
          // error: drop bytes until terminator
          nxt = cur;
        end
      endcase
    end
  end

endmodule

>>> sv/hex_float_text_parser_unit.sv
// hexadecimal floating point text parser
//
// item channel: one text byte per beat on character, item_valid / item_stall.
// a zero byte ends the text. bytes of the form [-]0xh.hhhp[+-]e are parsed
// on the fly; only the terminator yields a beat on the result channel.
// result channel: status, mantissa, binary_exponent with result_valid /
// result_stall. status is ok, missing zero, missing x or missing p; on an
// error the mantissa and exponent are zero and later bytes are dropped
// until the terminator.
// throughput: one byte per cycle while no result is held stalled, with no bubbles between texts.
// a terminator passes through the input register, then the parse step loads
// its result into the result register.
// the whole datapath advances only when the result register is empty or
// being taken; while result_stall holds a waiting result, item_stall is high
// and the input register, parse state and result hold still.
// reset (rst, synchronous) clears the parse state to expect a sign or zero
// and empties both registers.
module hex_float_text_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [7:0]         character,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         status,
  output logic signed [63:0] mantissa,
  output logic signed [31:0] binary_exponent
);
  import hfp_pkg::*;

  // input register
  logic          byte_valid;
  logic [7:0]    byte_q;

  // parse state and its step
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_res;

  // whole pipe moves unless a result sits stalled
  logic          advance;

  assign advance    = !(result_valid && result_stall);
  assign item_stall = !advance;

  hfp_step u_step (
    .cur (state),
    .chr (byte_q),
    .nxt (state_next),
    .res (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (advance) begin
      byte_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_q <= character;
    end
  end

  // accumulators are reset since later phases build on them
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSE_RESET;
    end else if (advance && byte_valid) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= byte_valid && step_res.done;
    end
  end

  // result payload loads only on a terminator beat
  always_ff @(posedge clk) begin
    if (advance && byte_valid && step_res.done) begin
      status          <= step_res.status;
      mantissa        <= step_res.mantissa;
      binary_exponent <= step_res.binary_exponent;
    end
  end

  // an error result carries no numbers
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != ST_OK) |-> (mantissa == 64'sd0) && (binary_exponent == 32'sd0))
    else $error("error result with nonzero payload");

  // a terminator returns the parser to its start phase
  assert property (@(posedge clk) disable iff (rst)
    advance && byte_valid && step_res.done |=> state.phase == PH_SIGN_OR_ZERO)
    else $error("parser not restarted after terminator");

  // error phase always holds an error code
  assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_ERROR |-> state.err != ST_OK)
    else $error("error phase without error code");

  // a stalled result freezes the parse state
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(state))
    else $error("parse state moved under stall");

endmodule
